// ----- design/pose_frame_receiver_macros.svh -----
// ----------------------------------------------------------------------------
// pose_frame_receiver_macros
// Assertion macros used by the pose frame receiver sequencer (pfr_back).
// ----------------------------------------------------------------------------
`ifndef POSE_FRAME_RECEIVER_MACROS_SVH
`define POSE_FRAME_RECEIVER_MACROS_SVH

// Check a property on every clock edge outside reset
`define PFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset
`define PFR_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- design/pfr_pkg.sv -----
// ----------------------------------------------------------------------------
// pfr_pkg
// Types, constants and single-precision helpers for the pose frame receiver.
// ----------------------------------------------------------------------------
package pfr_pkg;

  localparam logic [7:0]  HDR_CR        = 8'h0d;
  localparam logic [7:0]  HDR_LF        = 8'h0a;
  localparam logic [4:0]  PAYLOAD_LAST  = 5'd23;
  localparam logic [31:0] F_POS180      = 32'h4334_0000;
  localparam logic [31:0] F_NEG180      = 32'hC334_0000;
  localparam logic [31:0] F_POS360      = 32'h43B4_0000;
  localparam logic [31:0] F_ONE         = 32'h3F80_0000;
  localparam logic [31:0] CANON_NAN     = 32'h7FC0_0000;
  localparam logic [31:0] SIGN_BIT      = 32'h8000_0000;

  localparam int FRAME_Q_DEPTH = 2;
  localparam int OUT_Q_DEPTH   = 2;

  // Configuration register indexes
  localparam logic [2:0] REG_ANGLE_OFF = 3'd0;
  localparam logic [2:0] REG_COS_OFF   = 3'd1;
  localparam logic [2:0] REG_SIN_OFF   = 3'd2;
  localparam logic [2:0] REG_X_OFF     = 3'd3;
  localparam logic [2:0] REG_Y_OFF     = 3'd4;
  localparam logic [2:0] REG_MIRROR    = 3'd5;

  typedef enum logic [2:0] {
    PH_HUNT, PH_LF1, PH_BODY, PH_LF2, PH_CR2
  } phase_t;

  typedef enum logic [3:0] {
    B_IDLE, B_ANG, B_WRP1, B_WRP2, B_M1, B_M2, B_AX,
    B_M3, B_M4, B_AY, B_XO, B_YO, B_FIN
  } bstate_t;

  typedef struct packed {
    logic [31:0] ang;
    logic [31:0] gx;
    logic [31:0] gy;
  } frame_t;

  typedef struct packed {
    logic [31:0] angle_off;
    logic [31:0] cos_off;
    logic [31:0] sin_off;
    logic [31:0] x_off;
    logic [31:0] y_off;
    logic        mirror;
  } cfg_t;

  typedef struct packed {
    logic [31:0] angle;
    logic [31:0] x;
    logic [31:0] y;
  } pose_t;

  function automatic logic is_nan(logic [31:0] v);
    return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
  endfunction

  function automatic logic [31:0] canon(logic [31:0] v);
    return is_nan(v) ? CANON_NAN : v;
  endfunction

  // Order key: larger key means larger value (zeros not needed here)
  function automatic logic [31:0] okey(logic [31:0] v);
    return v[31] ? ~v : (v ^ SIGN_BIT);
  endfunction

  function automatic logic gt_180(logic [31:0] v);
    return !is_nan(v) && (okey(v) > okey(F_POS180));
  endfunction

  function automatic logic le_m180(logic [31:0] v);
    return !is_nan(v) && (okey(v) <= okey(F_NEG180));
  endfunction

  function automatic logic [4:0] lzc28(logic [27:0] v);
    logic [4:0] n;
    n = 5'd28;
    for (int i = 0; i < 28; i++) begin
      if (v[i]) n = 5'(27 - i);
    end
    return n;
  endfunction

  function automatic logic [5:0] lzc48(logic [47:0] v);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

  // Round to nearest even and pack; e >= 1, m[23] leading (0 only when e is 1)
  function automatic logic [31:0] round_pack(logic s, logic [9:0] e, logic [23:0] m,
                                             logic g, logic st);
    logic [24:0] mr;
    logic [10:0] f;
    mr = {1'b0, m} + {24'd0, g & (st | m[0])};
    f  = {1'b0, e} - 11'd1 + {9'd0, mr[24], mr[23]};
    if (f >= 11'd255) return {s, 8'hFF, 23'd0};
    return {s, f[7:0], mr[22:0]};
  endfunction

endpackage

// ----- design/pfr_fifo.sv -----
// ----------------------------------------------------------------------------
// pfr_fifo
// Small register queue with full and empty flags.
// ----------------------------------------------------------------------------
module pfr_fifo #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  // Store the pushed beat
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ----- design/pfr_fadd.sv -----
// ----------------------------------------------------------------------------
// pfr_fadd
// Four-stage single-precision adder/subtractor, round to nearest even.
// ----------------------------------------------------------------------------
module pfr_fadd (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic        sub,
  output logic        vld,
  output logic [31:0] res
);

  // Stage 1: unpack, order by magnitude, align
  logic [31:0] bb, xo, yo;
  logic        a_nan, b_nan, a_inf, b_inf, swap;
  logic [7:0]  ex, ey, d;
  logic [23:0] mx, my;
  logic [26:0] yext, ysh;

  always_comb begin
    bb    = b ^ (sub ? pfr_pkg::SIGN_BIT : 32'd0);
    a_nan = pfr_pkg::is_nan(a);
    b_nan = pfr_pkg::is_nan(bb);
    a_inf = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf = (bb[30:23] == 8'hFF) && (bb[22:0] == 23'd0);
    swap  = bb[30:0] > a[30:0];
    xo    = swap ? bb : a;
    yo    = swap ? a : bb;
    ex    = (xo[30:23] == 8'd0) ? 8'd1 : xo[30:23];
    ey    = (yo[30:23] == 8'd0) ? 8'd1 : yo[30:23];
    mx    = {xo[30:23] != 8'd0, xo[22:0]};
    my    = {yo[30:23] != 8'd0, yo[22:0]};
    d     = ex - ey;
    yext  = {my, 3'b000};
    if (d >= 8'd27) begin
      ysh = {26'd0, |my};
    end else begin
      ysh = (yext >> d) | {26'd0, |(yext & ~({27{1'b1}} << d))};
    end
  end

  logic        v1_r, s1_sign_r, s1_sub_r, s1_nan_r, s1_inf_r, s1_infs_r;
  logic [7:0]  s1_e_r;
  logic [26:0] s1_mx_r, s1_my_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= go;
  end

  always_ff @(posedge clk) begin
    s1_sign_r <= xo[31];
    s1_sub_r  <= xo[31] ^ yo[31];
    s1_nan_r  <= a_nan || b_nan || (a_inf && b_inf && (a[31] ^ bb[31]));
    s1_inf_r  <= a_inf || b_inf;
    s1_infs_r <= a_inf ? a[31] : bb[31];
    s1_e_r    <= ex;
    s1_mx_r   <= {mx, 3'b000};
    s1_my_r   <= ysh;
  end

  // Stage 2: add or subtract magnitudes
  logic        v2_r, s2_sign_r, s2_sub_r, s2_nan_r, s2_inf_r, s2_infs_r;
  logic [7:0]  s2_e_r;
  logic [27:0] s2_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    s2_sign_r <= s1_sign_r;
    s2_sub_r  <= s1_sub_r;
    s2_nan_r  <= s1_nan_r;
    s2_inf_r  <= s1_inf_r;
    s2_infs_r <= s1_infs_r;
    s2_e_r    <= s1_e_r;
    s2_sum_r  <= s1_sub_r ? ({1'b0, s1_mx_r} - {1'b0, s1_my_r})
                          : ({1'b0, s1_mx_r} + {1'b0, s1_my_r});
  end

  // Stage 3: count leading zeros
  logic        v3_r, s3_sign_r, s3_sub_r, s3_nan_r, s3_inf_r, s3_infs_r;
  logic [7:0]  s3_e_r;
  logic [27:0] s3_sum_r;
  logic [4:0]  s3_lz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    s3_sign_r <= s2_sign_r;
    s3_sub_r  <= s2_sub_r;
    s3_nan_r  <= s2_nan_r;
    s3_inf_r  <= s2_inf_r;
    s3_infs_r <= s2_infs_r;
    s3_e_r    <= s2_e_r;
    s3_sum_r  <= s2_sum_r;
    s3_lz_r   <= pfr_pkg::lzc28(s2_sum_r);
  end

  // Stage 4: normalise, round, pack
  logic [8:0]  sh, lzm1, em1, en;
  logic [26:0] norm;
  logic [31:0] res_nxt;

  always_comb begin
    lzm1 = {4'd0, s3_lz_r} - 9'd1;
    em1  = {1'b0, s3_e_r} - 9'd1;
    sh   = (lzm1 < em1) ? lzm1 : em1;
    if (s3_sum_r[27]) begin
      norm = {s3_sum_r[27:2], s3_sum_r[1] | s3_sum_r[0]};
      en   = {1'b0, s3_e_r} + 9'd1;
    end else begin
      norm = s3_sum_r[26:0] << sh;
      en   = {1'b0, s3_e_r} - sh;
    end
    if (s3_nan_r) begin
      res_nxt = pfr_pkg::CANON_NAN;
    end else if (s3_inf_r) begin
      res_nxt = {s3_infs_r, 8'hFF, 23'd0};
    end else if (s3_sum_r == 28'd0) begin
      res_nxt = {s3_sub_r ? 1'b0 : s3_sign_r, 31'd0};
    end else begin
      res_nxt = pfr_pkg::round_pack(s3_sign_r, {1'b0, en}, norm[26:3], norm[2], |norm[1:0]);
    end
  end

  logic        v4_r;
  logic [31:0] res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign vld = v4_r;
  assign res = res_r;

endmodule

// ----- design/pfr_fmul.sv -----
// ----------------------------------------------------------------------------
// pfr_fmul
// Three-stage single-precision multiplier, round to nearest even.
// ----------------------------------------------------------------------------
module pfr_fmul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        vld,
  output logic [31:0] res
);

  // Stage 1: unpack, specials, mantissa product
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [7:0]  ea, eb;
  logic [23:0] ma, mb;

  always_comb begin
    a_nan  = pfr_pkg::is_nan(a);
    b_nan  = pfr_pkg::is_nan(b);
    a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma     = {a[30:23] != 8'd0, a[22:0]};
    mb     = {b[30:23] != 8'd0, b[22:0]};
  end

  logic         v1_r, s1_sign_r, s1_nan_r, s1_inf_r, s1_zero_r;
  logic [10:0]  s1_e_r;
  logic [47:0]  s1_p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= go;
  end

  always_ff @(posedge clk) begin
    s1_sign_r <= a[31] ^ b[31];
    s1_nan_r  <= a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
    s1_inf_r  <= a_inf || b_inf;
    s1_zero_r <= a_zero || b_zero;
    s1_e_r    <= {3'd0, ea} + {3'd0, eb} - 11'd126;
    s1_p_r    <= ma * mb;
  end

  // Stage 2: count leading zeros of the product
  logic         v2_r, s2_sign_r, s2_nan_r, s2_inf_r, s2_zero_r;
  logic [10:0]  s2_e_r;
  logic [47:0]  s2_p_r;
  logic [5:0]   s2_lz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    s2_sign_r <= s1_sign_r;
    s2_nan_r  <= s1_nan_r;
    s2_inf_r  <= s1_inf_r;
    s2_zero_r <= s1_zero_r;
    s2_e_r    <= s1_e_r;
    s2_p_r    <= s1_p_r;
    s2_lz_r   <= pfr_pkg::lzc48(s1_p_r);
  end

  // Stage 3: shift into place (right for subnormal results), round, pack
  logic signed [10:0] e0, em1, lzs, sh, ef;
  logic [10:0] rs;
  logic [47:0] q;
  logic        stk;
  logic [31:0] res_nxt;

  always_comb begin
    e0  = $signed(s2_e_r);
    em1 = e0 - 11'sd1;
    lzs = $signed({5'd0, s2_lz_r});
    sh  = (em1 < lzs) ? em1 : lzs;
    rs  = 11'(-sh);
    stk = 1'b0;
    if (sh >= 11'sd0) begin
      q = s2_p_r << sh[5:0];
    end else if (rs >= 11'd48) begin
      q   = 48'd0;
      stk = |s2_p_r;
    end else begin
      q   = s2_p_r >> rs[5:0];
      stk = |(s2_p_r & ((48'd1 << rs[5:0]) - 48'd1));
    end
    ef = e0 - sh;
    if (s2_nan_r) begin
      res_nxt = pfr_pkg::CANON_NAN;
    end else if (s2_inf_r) begin
      res_nxt = {s2_sign_r, 8'hFF, 23'd0};
    end else if (s2_zero_r) begin
      res_nxt = {s2_sign_r, 31'd0};
    end else begin
      res_nxt = pfr_pkg::round_pack(s2_sign_r, ef[9:0], q[47:24], q[23],
                                    (|q[22:0]) | stk);
    end
  end

  logic        v3_r;
  logic [31:0] res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign vld = v3_r;
  assign res = res_r;

endmodule

// ----- design/pfr_front.sv -----
// ----------------------------------------------------------------------------
// pfr_front
// Byte framer: finds CR LF, 24 payload bytes, LF CR and queues the used floats.
// ----------------------------------------------------------------------------
module pfr_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            byte_vld,
  input  logic [7:0]      rx_byte,
  output logic            frame_push,
  output pfr_pkg::frame_t frame
);

  pfr_pkg::phase_t phase_r, phase_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] ang_r, gx_r, gy_r;

  // Hold phase and byte count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pfr_pkg::PH_HUNT;
      cnt_r   <= 5'd0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Advance the frame search on each byte
  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    frame_push = 1'b0;
    if (byte_vld) begin
      unique case (phase_r)
        pfr_pkg::PH_HUNT: begin
          phase_nxt = (rx_byte == pfr_pkg::HDR_CR) ? pfr_pkg::PH_LF1 : pfr_pkg::PH_HUNT;
        end
        pfr_pkg::PH_LF1: begin
          if (rx_byte == pfr_pkg::HDR_LF) begin
            cnt_nxt   = 5'd0;
            phase_nxt = pfr_pkg::PH_BODY;
          end else if (rx_byte != pfr_pkg::HDR_CR) begin
            phase_nxt = pfr_pkg::PH_HUNT;
          end
        end
        pfr_pkg::PH_BODY: begin
          if (cnt_r == pfr_pkg::PAYLOAD_LAST) begin
            cnt_nxt   = 5'd0;
            phase_nxt = pfr_pkg::PH_LF2;
          end else begin
            cnt_nxt = cnt_r + 5'd1;
          end
        end
        pfr_pkg::PH_LF2: begin
          phase_nxt = (rx_byte == pfr_pkg::HDR_LF) ? pfr_pkg::PH_CR2 : pfr_pkg::PH_HUNT;
        end
        pfr_pkg::PH_CR2: begin
          frame_push = (rx_byte == pfr_pkg::HDR_CR);
          phase_nxt  = pfr_pkg::PH_HUNT;
        end
        default: begin
          phase_nxt = pfr_pkg::PH_HUNT;
        end
      endcase
    end
  end

  // Shift in the little-endian bytes of floats 0, 3 and 4
  always_ff @(posedge clk) begin
    if (byte_vld && (phase_r == pfr_pkg::PH_BODY)) begin
      if (cnt_r < 5'd4)                     ang_r <= {rx_byte, ang_r[31:8]};
      if (cnt_r >= 5'd12 && cnt_r < 5'd16)  gx_r  <= {rx_byte, gx_r[31:8]};
      if (cnt_r >= 5'd16 && cnt_r < 5'd20)  gy_r  <= {rx_byte, gy_r[31:8]};
    end
  end

  assign frame.ang = ang_r;
  assign frame.gx  = gx_r;
  assign frame.gy  = gy_r;

endmodule

// ----- design/pfr_back.sv -----
// ----------------------------------------------------------------------------
// pfr_back
// Pose sequencer: runs the heading and position transform on one shared
// adder and one shared multiplier, then queues the pose.
// ----------------------------------------------------------------------------
`include "pose_frame_receiver_macros.svh"

module pfr_back (
  input  logic            clk,
  input  logic            rst_n,
  input  pfr_pkg::cfg_t   cfg,
  input  logic            fq_empty,
  input  pfr_pkg::frame_t fq_frame,
  output logic            fq_pop,
  input  logic            out_full,
  output logic            out_push,
  output pfr_pkg::pose_t  pose
);

  pfr_pkg::bstate_t state_r, state_nxt;
  logic        wait_r, wait_nxt;
  logic        ld_frame;
  logic [31:0] ang_r, gx_r, gy_r, x_r, y_r, p1_r, p2_r;

  logic        add_go, add_sub, add_vld;
  logic [31:0] add_a, add_b, add_res;
  logic        mul_go, mul_vld;
  logic [31:0] mul_a, mul_b, mul_res;

  pfr_fadd u_fadd (
    .clk (clk), .rst_n (rst_n), .go (add_go), .a (add_a), .b (add_b),
    .sub (add_sub), .vld (add_vld), .res (add_res)
  );

  pfr_fmul u_fmul (
    .clk (clk), .rst_n (rst_n), .go (mul_go), .a (mul_a), .b (mul_b),
    .vld (mul_vld), .res (mul_res)
  );

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfr_pkg::B_IDLE;
      wait_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wait_r  <= wait_nxt;
    end
  end

  // Operand selection per step
  always_comb begin
    add_a   = ang_r;
    add_b   = pfr_pkg::F_POS360;
    add_sub = 1'b0;
    mul_a   = gx_r;
    mul_b   = cfg.cos_off;
    unique case (state_r)
      pfr_pkg::B_ANG:  begin add_b = cfg.angle_off; add_sub = 1'b1; end
      pfr_pkg::B_WRP1: begin add_sub = 1'b1; end
      pfr_pkg::B_AX:   begin add_a = p1_r; add_b = p2_r; end
      pfr_pkg::B_AY:   begin add_a = p1_r; add_b = p2_r; add_sub = 1'b1; end
      pfr_pkg::B_XO:   begin add_a = x_r; add_b = cfg.x_off; add_sub = 1'b1; end
      pfr_pkg::B_YO:   begin add_a = y_r; add_b = cfg.y_off; add_sub = 1'b1; end
      pfr_pkg::B_M2:   begin mul_a = gy_r; mul_b = cfg.sin_off; end
      pfr_pkg::B_M3:   begin mul_a = gy_r; end
      pfr_pkg::B_M4:   begin mul_b = cfg.sin_off; end
      default: begin end
    endcase
  end

  // Step through the transform, one unit operation at a time
  always_comb begin
    state_nxt = state_r;
    wait_nxt  = wait_r;
    add_go    = 1'b0;
    mul_go    = 1'b0;
    fq_pop    = 1'b0;
    ld_frame  = 1'b0;
    out_push  = 1'b0;
    unique case (state_r)
      pfr_pkg::B_IDLE: begin
        if (!fq_empty) begin
          fq_pop    = 1'b1;
          ld_frame  = 1'b1;
          state_nxt = pfr_pkg::B_ANG;
        end
      end
      pfr_pkg::B_ANG, pfr_pkg::B_AX, pfr_pkg::B_AY, pfr_pkg::B_XO, pfr_pkg::B_YO: begin
        if (!wait_r) begin
          add_go   = 1'b1;
          wait_nxt = 1'b1;
        end else if (add_vld) begin
          wait_nxt = 1'b0;
          unique case (state_r)
            pfr_pkg::B_ANG: state_nxt = pfr_pkg::B_WRP1;
            pfr_pkg::B_AX:  state_nxt = pfr_pkg::B_M3;
            pfr_pkg::B_AY:  state_nxt = pfr_pkg::B_XO;
            pfr_pkg::B_XO:  state_nxt = pfr_pkg::B_YO;
            default:        state_nxt = pfr_pkg::B_FIN;
          endcase
        end
      end
      pfr_pkg::B_WRP1: begin
        if (!wait_r) begin
          if (pfr_pkg::gt_180(ang_r)) begin
            add_go   = 1'b1;
            wait_nxt = 1'b1;
          end else begin
            state_nxt = pfr_pkg::B_WRP2;
          end
        end else if (add_vld) begin
          wait_nxt  = 1'b0;
          state_nxt = pfr_pkg::B_WRP2;
        end
      end
      pfr_pkg::B_WRP2: begin
        if (!wait_r) begin
          if (pfr_pkg::le_m180(ang_r)) begin
            add_go   = 1'b1;
            wait_nxt = 1'b1;
          end else begin
            state_nxt = pfr_pkg::B_M1;
          end
        end else if (add_vld) begin
          wait_nxt  = 1'b0;
          state_nxt = pfr_pkg::B_M1;
        end
      end
      pfr_pkg::B_M1, pfr_pkg::B_M2, pfr_pkg::B_M3, pfr_pkg::B_M4: begin
        if (!wait_r) begin
          mul_go   = 1'b1;
          wait_nxt = 1'b1;
        end else if (mul_vld) begin
          wait_nxt = 1'b0;
          unique case (state_r)
            pfr_pkg::B_M1: state_nxt = pfr_pkg::B_M2;
            pfr_pkg::B_M2: state_nxt = pfr_pkg::B_AX;
            pfr_pkg::B_M3: state_nxt = pfr_pkg::B_M4;
            default:       state_nxt = pfr_pkg::B_AY;
          endcase
        end
      end
      pfr_pkg::B_FIN: begin
        if (!out_full) begin
          out_push  = 1'b1;
          state_nxt = pfr_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = pfr_pkg::B_IDLE;
        wait_nxt  = 1'b0;
      end
    endcase
  end

  // Capture the frame and the unit results
  always_ff @(posedge clk) begin
    if (ld_frame) begin
      ang_r <= fq_frame.ang ^ pfr_pkg::SIGN_BIT;
      gx_r  <= fq_frame.gx;
      gy_r  <= fq_frame.gy;
    end
    if (add_vld) begin
      priority case (state_r)
        pfr_pkg::B_AX, pfr_pkg::B_XO: x_r   <= add_res;
        pfr_pkg::B_AY, pfr_pkg::B_YO: y_r   <= add_res;
        default:                      ang_r <= add_res;
      endcase
    end
    if (mul_vld) begin
      if (state_r == pfr_pkg::B_M1 || state_r == pfr_pkg::B_M3) p1_r <= mul_res;
      else                                                      p2_r <= mul_res;
    end
  end

  // Apply mirror, fold -180 to 180 and canonicalise NaNs
  logic [31:0] ang_m, x_m;

  always_comb begin
    ang_m = cfg.mirror ? (ang_r ^ pfr_pkg::SIGN_BIT) : ang_r;
    x_m   = cfg.mirror ? (x_r ^ pfr_pkg::SIGN_BIT) : x_r;
    if (ang_m == pfr_pkg::F_NEG180) ang_m = pfr_pkg::F_POS180;
    pose.angle = pfr_pkg::canon(ang_m);
    pose.x     = pfr_pkg::canon(x_m);
    pose.y     = pfr_pkg::canon(y_r);
  end

  `PFR_ASSERT(a_pop_in_idle, fq_pop |-> state_r == pfr_pkg::B_IDLE, "frame taken outside idle")
  `PFR_ASSERT(a_push_room, out_push |-> !out_full, "pose pushed into full queue")
  `PFR_ASSERT(a_push_then_idle, out_push |=> state_r == pfr_pkg::B_IDLE, "no return to idle")
  `PFR_NEVER(a_one_unit, add_vld && mul_vld, "both units returned together")

endmodule

// ----- design/pose_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// pose_frame_receiver
// Serial pose frame receiver with single-precision heading/position correction.
// ----------------------------------------------------------------------------
// One byte is taken per clock whenever full is low; full rises only while the
// queue of decoded frames (FRAME_Q_DEPTH entries) waits on the transform. A
// good trailer CR queues a frame, and the transform then works out the pose:
// nine or ten operations run one after another on a shared adder and a shared
// multiplier. Poses wait in an OUT_Q_DEPTH entry queue until popped.
// Configuration writes are always taken (cfg_ready is high) and must be made
// while no frame is being processed.
// ----------------------------------------------------------------------------
module pose_frame_receiver #(
  parameter int FRAME_Q_DEPTH = pfr_pkg::FRAME_Q_DEPTH,
  parameter int OUT_Q_DEPTH   = pfr_pkg::OUT_Q_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_angle_out,
  output logic [31:0] out_x_out,
  output logic [31:0] out_y_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  pfr_pkg::cfg_t   cfg_r;
  pfr_pkg::frame_t fr_in, fr_out;
  pfr_pkg::pose_t  pose_in, pose_out;
  logic            fr_push, fq_full, fq_empty, fq_pop;
  logic            oq_push, oq_full;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.angle_off <= 32'd0;
      cfg_r.cos_off   <= pfr_pkg::F_ONE;
      cfg_r.sin_off   <= 32'd0;
      cfg_r.x_off     <= 32'd0;
      cfg_r.y_off     <= 32'd0;
      cfg_r.mirror    <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pfr_pkg::REG_ANGLE_OFF: cfg_r.angle_off <= cfg_data;
        pfr_pkg::REG_COS_OFF:   cfg_r.cos_off   <= cfg_data;
        pfr_pkg::REG_SIN_OFF:   cfg_r.sin_off   <= cfg_data;
        pfr_pkg::REG_X_OFF:     cfg_r.x_off     <= cfg_data;
        pfr_pkg::REG_Y_OFF:     cfg_r.y_off     <= cfg_data;
        pfr_pkg::REG_MIRROR:    cfg_r.mirror    <= cfg_data[0];
        default: begin end
      endcase
    end
  end

  assign full = fq_full;

  pfr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_vld   (push && !fq_full),
    .rx_byte    (in_rx_byte),
    .frame_push (fr_push),
    .frame      (fr_in)
  );

  pfr_fifo #(.WIDTH($bits(pfr_pkg::frame_t)), .DEPTH(FRAME_Q_DEPTH)) u_frame_q (
    .clk (clk), .rst_n (rst_n),
    .push (fr_push), .wdata (fr_in), .full (fq_full),
    .pop (fq_pop), .rdata (fr_out), .empty (fq_empty)
  );

  pfr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .fq_empty (fq_empty),
    .fq_frame (fr_out),
    .fq_pop   (fq_pop),
    .out_full (oq_full),
    .out_push (oq_push),
    .pose     (pose_in)
  );

  pfr_fifo #(.WIDTH($bits(pfr_pkg::pose_t)), .DEPTH(OUT_Q_DEPTH)) u_out_q (
    .clk (clk), .rst_n (rst_n),
    .push (oq_push), .wdata (pose_in), .full (oq_full),
    .pop (pop), .rdata (pose_out), .empty (empty)
  );

  assign out_angle_out = pose_out.angle;
  assign out_x_out     = pose_out.x;
  assign out_y_out     = pose_out.y;

endmodule

// ----- tb/tb_pose_frame_receiver.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pose_frame_receiver
// Self-checking bench for the serial pose frame receiver: byte streams of good,
// broken and noisy frames go in, and every pose that comes out is compared with
// a single-precision software copy of the frame parser and pose transform.
// ----------------------------------------------------------------------------
module tb_pose_frame_receiver;
  import pfr_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 80;

  logic        clk;
  logic        rst_n;
  logic        push;
  logic        full;
  logic [7:0]  in_rx_byte;
  logic        empty;
  logic        pop;
  logic [31:0] out_angle_out;
  logic [31:0] out_x_out;
  logic [31:0] out_y_out;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  // Predictor state
  cfg_t        regs_shadow;
  int          parse_phase;
  int          body_count;
  logic [7:0]  body_bytes [24];
  pose_t       pending_poses [$];

  int          mismatches;
  int          cycles;
  bit          gaps_on;
  int          rx_hold_req;

  pose_frame_receiver uut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full), .in_rx_byte(in_rx_byte),
    .empty(empty), .pop(pop),
    .out_angle_out(out_angle_out), .out_x_out(out_x_out), .out_y_out(out_y_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Single-precision arithmetic: compute in double, round once to single.
  // Double rounding is harmless for one add or multiply of two singles.
  // ---------------------------------------------------------------------------
  function automatic real to_double(logic [31:0] v);
    real r;
    if (v[30:23] == 8'hFF)
      return $bitstoreal({v[31], 11'h7FF, v[22:0], 29'd0});
    if (v[30:23] == 8'd0) begin
      r = v[22:0];
      repeat (149) r = r / 2.0;
      return v[31] ? -r : r;
    end
    return $bitstoreal({v[31], 11'(v[30:23]) + 11'd896, v[22:0], 29'd0});
  endfunction

  function automatic logic [31:0] to_single(real r);
    logic [63:0] d;
    logic [63:0] sig;
    logic [63:0] kept;
    int          eb;
    int          sh;
    logic        g;
    logic        st;
    d = $realtobits(r);
    if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? CANON_NAN : {d[63], 8'hFF, 23'd0};
    if (d[62:52] == 11'd0) return {d[63], 31'd0};
    eb  = int'(d[62:52]) - 1023 + 127;
    sig = {11'd0, 1'b1, d[51:0]};
    sh  = (eb >= 1) ? 29 : 30 - eb;
    if (sh > 60) sh = 60;
    kept = sig >> sh;
    g    = sig[sh-1];
    st   = (sig & ((64'd1 << (sh - 1)) - 64'd1)) != 0;
    kept = kept + 64'(g & (st | kept[0]));
    if (eb >= 1) begin
      if (kept[24]) begin
        kept = kept >> 1;
        eb++;
      end
      if (eb >= 255) return {d[63], 8'hFF, 23'd0};
      return {d[63], 8'(eb), kept[22:0]};
    end
    return {d[63], kept[30:0]};
  endfunction

  function automatic logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
    return to_single(to_double(a) + to_double(b));
  endfunction

  function automatic logic [31:0] fsub(logic [31:0] a, logic [31:0] b);
    return to_single(to_double(a) - to_double(b));
  endfunction

  function automatic logic [31:0] fmul(logic [31:0] a, logic [31:0] b);
    return to_single(to_double(a) * to_double(b));
  endfunction

  // Compute the pose for the frame currently held in body_bytes
  function automatic pose_t transform_frame();
    logic [31:0] a;
    logic [31:0] gx;
    logic [31:0] gy;
    logic [31:0] x;
    logic [31:0] y;
    pose_t       p;
    a  = {body_bytes[3], body_bytes[2], body_bytes[1], body_bytes[0]} ^ SIGN_BIT;
    gx = {body_bytes[15], body_bytes[14], body_bytes[13], body_bytes[12]};
    gy = {body_bytes[19], body_bytes[18], body_bytes[17], body_bytes[16]};
    a = fsub(a, regs_shadow.angle_off);
    if (to_double(a) > 180.0) a = fsub(a, F_POS360);
    if (to_double(a) <= -180.0) a = fadd(a, F_POS360);
    x = fadd(fmul(gx, regs_shadow.cos_off), fmul(gy, regs_shadow.sin_off));
    y = fsub(fmul(gy, regs_shadow.cos_off), fmul(gx, regs_shadow.sin_off));
    x = fsub(x, regs_shadow.x_off);
    y = fsub(y, regs_shadow.y_off);
    if (regs_shadow.mirror) begin
      a = a ^ SIGN_BIT;
      x = x ^ SIGN_BIT;
    end
    if (to_double(a) == -180.0) a = F_POS180;
    p.angle = canon(a);
    p.x     = canon(x);
    p.y     = canon(y);
    return p;
  endfunction

  // Advance the frame parser by one byte
  task automatic parse_byte(input logic [7:0] b);
    case (parse_phase)
      0: parse_phase = (b == HDR_CR) ? 1 : 0;
      1: begin
        if (b == HDR_LF) begin
          body_count  = 0;
          parse_phase = 2;
        end else if (b != HDR_CR) begin
          parse_phase = 0;
        end
      end
      2: begin
        body_bytes[body_count] = b;
        body_count++;
        if (body_count >= 24) begin
          body_count  = 0;
          parse_phase = 3;
        end
      end
      3: parse_phase = (b == HDR_LF) ? 4 : 0;
      default: begin
        if (b == HDR_CR) pending_poses.push_back(transform_frame());
        parse_phase = 0;
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Monitors: input beats feed the predictor, output beats are checked
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && push && !full) parse_byte(in_rx_byte);
  end

  always @(posedge clk) begin
    pose_t want;
    if (rst_n && pop && !empty) begin
      if (pending_poses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pose %h %h %h", out_angle_out, out_x_out, out_y_out);
      end else begin
        want = pending_poses.pop_front();
        if (want.angle !== out_angle_out || want.x !== out_x_out || want.y !== out_y_out)
        begin
          mismatches++;
          if (mismatches <= 10)
            $display("pose mismatch: expected %h %h %h, got %h %h %h",
                     want.angle, want.x, want.y, out_angle_out, out_x_out, out_y_out);
        end
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold when asked
  always @(posedge clk) begin
    int stall_left;
    if (!rst_n) begin
      pop <= 1'b0;
      stall_left = 0;
    end else if (rx_hold_req > 0) begin
      pop <= 1'b0;
      rx_hold_req = rx_hold_req - 1;
    end else if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left--;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      pop <= 1'b0;
      stall_left = $urandom_range(0, 13);
    end else begin
      pop <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    push       <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic stop_sending();
    push <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    stop_sending();
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ANGLE_OFF: regs_shadow.angle_off = value;
      REG_COS_OFF:   regs_shadow.cos_off   = value;
      REG_SIN_OFF:   regs_shadow.sin_off   = value;
      REG_X_OFF:     regs_shadow.x_off     = value;
      REG_Y_OFF:     regs_shadow.y_off     = value;
      REG_MIRROR:    regs_shadow.mirror    = value[0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [31:0] ang, input logic [31:0] c, input logic [31:0] s,
                           input logic [31:0] xo, input logic [31:0] yo, input logic [31:0] mir);
    wait_drained();
    write_reg(REG_ANGLE_OFF, ang);
    write_reg(REG_COS_OFF, c);
    write_reg(REG_SIN_OFF, s);
    write_reg(REG_X_OFF, xo);
    write_reg(REG_Y_OFF, yo);
    write_reg(REG_MIRROR, mir);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_float();
    logic [31:0] specials [12];
    specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                 32'h7FC0_0001, 32'h0000_0001, 32'h807F_FFFF, 32'h7F7F_FFFF,
                 F_POS180, F_NEG180, F_POS360, 32'hFFFF_FFFF};
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return specials[$urandom_range(0, 11)];
      2: return to_single(real'(int'($urandom_range(0, 4000)) - 2000) / 8.0);
      default: return to_single(real'(int'($urandom_range(0, 1440000)) - 720000) / 1000.0);
    endcase
  endfunction

  // One frame; a wrong byte may replace position spoil (negative for none)
  task automatic send_frame(input logic [31:0] ang, input logic [31:0] gx,
                            input logic [31:0] gy, input int extra_cr, input int spoil);
    logic [7:0]  beat [$];
    logic [31:0] words [6];
    words = '{ang, $urandom, $urandom, gx, gy, $urandom};
    beat.push_back(HDR_CR);
    repeat (extra_cr) beat.push_back(HDR_CR);
    beat.push_back(HDR_LF);
    foreach (words[w])
      for (int k = 0; k < 4; k++) beat.push_back(words[w][8*k +: 8]);
    beat.push_back(HDR_LF);
    beat.push_back(HDR_CR);
    if (spoil >= 0 && spoil < beat.size()) beat[spoil] = 8'($urandom);
    foreach (beat[i]) send_byte(beat[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_angle_wrap();
    send_frame(32'h0000_0000, 32'h3F80_0000, 32'h4000_0000, 0, -1);
    send_frame(F_POS180, 32'h0000_0000, 32'h8000_0000, 0, -1);
    send_frame(F_NEG180, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 0, -1);
    send_frame(32'h4335_0000, 32'h7F80_0000, 32'hFF80_0000, 0, -1);
    send_frame(32'hC335_0000, 32'h7FC0_0001, 32'h0000_0001, 0, -1);
    send_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h807F_FFFF, 0, -1);
  endtask

  task automatic test_framing_errors();
    // repeated CR before LF is tolerated
    send_frame(to_single(45.5), to_single(3.0), to_single(-7.25), 3, -1);
    // a wrong byte in each header and trailer position
    send_frame(to_single(10.0), to_single(1.0), to_single(1.0), 0, 0);
    send_frame(to_single(11.0), to_single(1.0), to_single(1.0), 0, 1);
    send_frame(to_single(12.0), to_single(1.0), to_single(1.0), 0, 26);
    send_frame(to_single(13.0), to_single(1.0), to_single(1.0), 0, 27);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HDR_LF);
    send_frame(to_single(-90.0), to_single(2.0), to_single(4.0), 1, -1);
  endtask

  task automatic test_register_extremes();
    write_all(to_single(30.0), to_single(0.866), to_single(0.5),
              to_single(100.0), to_single(-50.0), 32'd1);
    send_frame(to_single(-150.0), to_single(10.0), to_single(20.0), 0, -1);
    send_frame(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0, -1);
    write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF);
    send_frame(to_single(1.0), to_single(1.0), to_single(1.0), 0, -1);
    write_all(32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h0000_0001, 32'h7F80_0000, 32'h8000_0000,
              32'hFFFF_FFFE);
    send_frame(to_single(-1.0), to_single(2.0), to_single(-3.0), 0, -1);
    write_all(F_NEG180, F_ONE, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'd0);
    send_frame(F_NEG180, to_single(5.0), to_single(6.0), 0, -1);
    send_frame(32'h0000_0000, to_single(5.0), to_single(6.0), 0, -1);
  endtask

  task automatic test_random_traffic(input int n_bytes);
    int sent;
    sent = 0;
    while (sent < n_bytes) begin
      if ($urandom_range(0, 39) == 0) begin
        write_all(rand_float(), rand_float(), rand_float(), rand_float(), rand_float(),
                  $urandom);
      end
      if ($urandom_range(0, 7) == 0) begin
        send_byte($urandom_range(0, 3) == 0 ? HDR_CR : 8'($urandom));
        sent++;
      end else begin
        send_frame(rand_float(), rand_float(), rand_float(),
                   ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0,
                   ($urandom_range(0, 9) == 0) ? $urandom_range(0, 27) : -1);
        sent += 28;
      end
    end
  endtask

  task automatic test_receiver_hold();
    rx_hold_req = 600;
    repeat (8) send_frame(rand_float(), rand_float(), rand_float(), 0, -1);
  endtask

  task automatic test_sender_pause();
    repeat (3) send_frame(rand_float(), rand_float(), rand_float(), 0, -1);
    stop_sending();
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (3) send_frame(rand_float(), rand_float(), rand_float(), 0, -1);
  endtask

  initial begin
    rst_n       = 1'b0;
    push        = 1'b0;
    pop         = 1'b0;
    in_rx_byte  = 8'd0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_ANGLE_OFF;
    cfg_data    = 32'd0;
    mismatches  = 0;
    cycles      = 0;
    gaps_on     = 1'b1;
    rx_hold_req = 0;
    parse_phase = 0;
    body_count  = 0;
    foreach (body_bytes[i]) body_bytes[i] = 8'd0;
    regs_shadow = '{angle_off: 32'd0, cos_off: F_ONE, sin_off: 32'd0,
                    x_off: 32'd0, y_off: 32'd0, mirror: 1'b0};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_angle_wrap();
    test_framing_errors();
    test_register_extremes();
    test_receiver_hold();
    test_random_traffic(700);
    test_sender_pause();
    gaps_on = 1'b0;
    test_random_traffic(300);

    stop_sending();
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
